[sv/rsq_pkg.sv]
// Shared types, constants and widening tables for the RGB565 resize and int8 quantizer.
// Used by rsq_round and rgb565_resize_int8_quantizer_core; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package rsq_pkg;

   // Default geometry, handed to the top level parameters.
   localparam int SOURCE_WIDTH_DEF  = 240;
   localparam int SOURCE_HEIGHT_DEF = 240;
   localparam int OUT_SIZE_DEF      = 96;

   // Field widths.
   localparam int PIXEL_W     = 16;
   localparam int INV_SCALE_W = 24;
   localparam int ZP_W        = 8;
   localparam int Q_W         = 8;
   localparam int POS_W       = 7;
   localparam int PROD_W      = 32;
   localparam int CSR_INDEX_W = 1;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_INVERSE_SCALE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_POINT    = 1'b1;

   localparam logic [INV_SCALE_W-1:0] INV_SCALE_RESET = 24'd8355840;
   localparam logic signed [ZP_W-1:0] ZP_RESET        = -8'sd1;

   // Half of the divisor 255 * 65536, added before the truncating divide.
   localparam logic [PROD_W:0] ROUND_HALF = 33'd8355840;

   typedef logic [7:0] widen5_tab_type [32];
   typedef logic [7:0] widen6_tab_type [64];

   function automatic widen5_tab_type build_widen5();
      widen5_tab_type t;
      for (int c = 0; c < 32; c++) begin
         t[c] = 8'((c * 255) / 31);
      end
      return t;
   endfunction

   function automatic widen6_tab_type build_widen6();
      widen6_tab_type t;
      for (int c = 0; c < 64; c++) begin
         t[c] = 8'((c * 255) / 63);
      end
      return t;
   endfunction

   localparam widen5_tab_type WIDEN5 = build_widen5();
   localparam widen6_tab_type WIDEN6 = build_widen6();

   // Magnitude of (2v - 255) * inverse_scale and the sign of (2v - 255).
   typedef struct packed {
      logic [PROD_W-1:0] prod;
      logic              neg;
   } chan_prod_type;

   // 2v - 255 is always odd: for v >= 128 it is {v[6:0], 1}, below that it is
   // the negation of {~v[6:0], 1}.
   function automatic chan_prod_type scale_chan(input logic [7:0] v,
                                                input logic [INV_SCALE_W-1:0] s);
      chan_prod_type res;
      logic [7:0]    mag;
      mag      = {(v[7] ? v[6:0] : ~v[6:0]), 1'b1};
      res.neg  = ~v[7];
      res.prod = {24'd0, mag} * {8'd0, s};
      return res;
   endfunction

endpackage

`default_nettype wire

[sv/rsq_round.sv]
// One channel of the quantizer back end: divide by 255 * 65536 with rounding half
// away from zero, add the zero point and saturate to int8. Depends on rsq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rsq_round (
   input  rsq_pkg::chan_prod_type         chan,
   input  logic signed [rsq_pkg::ZP_W-1:0] zp_offset,
   output logic signed [rsq_pkg::Q_W-1:0]  q
);
   import rsq_pkg::*;

   logic [PROD_W:0]    sum_w;
   logic [16:0]        m;
   logic [25:0]        m257;
   logic [9:0]         r0;
   logic [17:0]        r255;
   logic [17:0]        rem;
   logic [9:0]         r;
   logic signed [11:0] mag_s;
   logic signed [11:0] qw;

   // floor(N / (255 * 2^16)) equals floor(floor(N / 2^16) / 255). The quotient by
   // 255 is estimated with 257 / 2^16, which is low by at most one, then fixed.
   always_comb begin
      sum_w = {1'b0, chan.prod} + ROUND_HALF;
      m     = sum_w[PROD_W:16];
      m257  = {9'd0, m} + {1'b0, m, 8'd0};
      r0    = m257[25:16];
      r255  = {r0, 8'd0} - {8'd0, r0};
      rem   = {1'b0, m} - r255;
      r     = (rem >= 18'd255) ? r0 + 10'd1 : r0;
      mag_s = $signed({2'b00, r});
      qw    = (chan.neg ? -mag_s : mag_s) + $signed({{4{zp_offset[ZP_W-1]}}, zp_offset});
      if (qw > 12'sd127) begin
         q = 8'sd127;
      end else if (qw < -12'sd128) begin
         q = -8'sd128;
      end else begin
         q = qw[Q_W-1:0];
      end
   end

endmodule

`default_nettype wire

[sv/rgb565_resize_int8_quantizer_core.sv]
// A kept pixel goes through the stage-1 and output registers to rsp_tvalid. Throughput:
// one req beat per clock unless a stalled rsp side fills both registers; the sampling
// counters and the three channel multipliers sit before one pipeline register, rounding and
// saturation before the output register. Beats that are not sampled produce no rsp beat.
// Reset (synchronous): counters cleared, configuration at its defaults, and pixels
// are dropped until a beat with the start-of-frame flag arrives.
// Depends on rsq_pkg and rsq_round.
`timescale 1ns / 1ps
`default_nettype none

module rgb565_resize_int8_quantizer_core #(
   parameter int SOURCE_WIDTH  = rsq_pkg::SOURCE_WIDTH_DEF,
   parameter int SOURCE_HEIGHT = rsq_pkg::SOURCE_HEIGHT_DEF,
   parameter int OUT_SIZE      = rsq_pkg::OUT_SIZE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // Configuration port.
   input  logic                              csr_we,
   input  logic [rsq_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rsq_pkg::INV_SCALE_W-1:0]   csr_wdata,
   // Source pixels.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [15:0]                       req_tdata,   // pixel[15:0]
   input  logic [0:0]                        req_tuser,   // start_of_frame[0]
   // Quantized pixels.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // red_q[7:0], green_q[15:8], blue_q[23:16], out_column[30:24], out_row[37:31], zero pad
   output logic [39:0]                       rsp_tdata,
   output logic                              rsp_tlast    // end_of_frame
);
   import rsq_pkg::*;

   localparam int COL_W = $clog2(SOURCE_WIDTH + 1);
   localparam int ROW_W = $clog2(SOURCE_HEIGHT + 1);
   localparam int DX_W  = $clog2(OUT_SIZE + 1);
   localparam int REM_W = $clog2(2 * OUT_SIZE);

   localparam int TX_STEP     = SOURCE_WIDTH / OUT_SIZE;
   localparam int TX_FRAC     = SOURCE_WIDTH % OUT_SIZE;
   localparam int TX_INIT     = (SOURCE_WIDTH / 2) / OUT_SIZE;
   localparam int TX_REM_INIT = (SOURCE_WIDTH / 2) % OUT_SIZE;
   localparam int TY_STEP     = SOURCE_HEIGHT / OUT_SIZE;
   localparam int TY_FRAC     = SOURCE_HEIGHT % OUT_SIZE;
   localparam int TY_INIT     = (SOURCE_HEIGHT / 2) / OUT_SIZE;
   localparam int TY_REM_INIT = (SOURCE_HEIGHT / 2) % OUT_SIZE;

   // Configuration.
   logic [INV_SCALE_W-1:0]   inv_scale_ff;
   logic signed [ZP_W-1:0]   zp_offset_ff;

   // Sampling state. tx/ty are the source column and row picked by the next output
   // position, kept as quotient and remainder of (d * SIZE + SIZE / 2) / OUT_SIZE.
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [DX_W-1:0]  dx_ff, dx_in;
   logic [DX_W-1:0]  dy_ff, dy_in;
   logic [COL_W-1:0] tx_ff, tx_in;
   logic [ROW_W-1:0] ty_ff, ty_in;
   logic [REM_W-1:0] tx_rem_ff, tx_rem_in;
   logic [REM_W-1:0] ty_rem_ff, ty_rem_in;
   logic             done_ff, done_in;

   // Pipeline stage after the multipliers.
   logic             s1_valid_ff;
   chan_prod_type    s1_red_ff, s1_green_ff, s1_blue_ff;
   logic [POS_W-1:0] s1_col_ff, s1_row_ff;
   logic             s1_last_ff;

   // Output register.
   logic             rsp_valid_ff;
   logic [Q_W-1:0]   rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic [POS_W-1:0] rsp_col_ff, rsp_row_ff;
   logic             rsp_last_ff;

   logic                    accept;
   logic                    s1_ready;
   logic                    rsp_ready;
   logic                    emit;
   logic                    last;
   logic [COL_W-1:0]        col_c;
   logic [ROW_W-1:0]        row_c;
   logic [DX_W-1:0]         dx_c, dy_c, dx_inc, dy_inc;
   logic [COL_W-1:0]        tx_c;
   logic [ROW_W-1:0]        ty_c;
   logic [REM_W-1:0]        tx_rem_c, ty_rem_c, tx_rem_sum, ty_rem_sum;
   logic                    tx_carry, ty_carry;
   logic [COL_W:0]          tx_sum;
   logic [ROW_W:0]          ty_sum;
   logic                    done_c;
   logic [COL_W-1:0]        col_inc;
   chan_prod_type           red_p, green_p, blue_p;
   logic signed [Q_W-1:0]   red_q, green_q, blue_q;

   assign rsp_ready  = !rsp_valid_ff || rsp_tready;
   assign s1_ready   = !s1_valid_ff || rsp_ready;
   assign req_tready = s1_ready;
   assign accept     = req_tvalid && s1_ready;

   // Sampling decision and counter update for the beat on the req side.
   always_comb begin
      if (req_tuser[0]) begin
         col_c    = '0;
         row_c    = '0;
         dx_c     = '0;
         dy_c     = '0;
         tx_c     = COL_W'(TX_INIT);
         ty_c     = ROW_W'(TY_INIT);
         tx_rem_c = REM_W'(TX_REM_INIT);
         ty_rem_c = REM_W'(TY_REM_INIT);
         done_c   = 1'b0;
      end else begin
         col_c    = col_ff;
         row_c    = row_ff;
         dx_c     = dx_ff;
         dy_c     = dy_ff;
         tx_c     = tx_ff;
         ty_c     = ty_ff;
         tx_rem_c = tx_rem_ff;
         ty_rem_c = ty_rem_ff;
         done_c   = done_ff;
      end

      dx_inc     = dx_c + DX_W'(1);
      dy_inc     = dy_c + DX_W'(1);
      tx_rem_sum = tx_rem_c + REM_W'(TX_FRAC);
      ty_rem_sum = ty_rem_c + REM_W'(TY_FRAC);
      tx_carry   = (tx_rem_sum >= REM_W'(OUT_SIZE));
      ty_carry   = (ty_rem_sum >= REM_W'(OUT_SIZE));
      tx_sum     = (COL_W + 1)'(tx_c) + (COL_W + 1)'(TX_STEP) + (COL_W + 1)'(tx_carry);
      ty_sum     = (ROW_W + 1)'(ty_c) + (ROW_W + 1)'(TY_STEP) + (ROW_W + 1)'(ty_carry);
      col_inc    = col_c + COL_W'(1);

      emit = !done_c && (row_c >= ty_c) && (col_c >= tx_c);
      last = 1'b0;

      col_in    = col_c;
      row_in    = row_c;
      dx_in     = dx_c;
      dy_in     = dy_c;
      tx_in     = tx_c;
      ty_in     = ty_c;
      tx_rem_in = tx_rem_c;
      ty_rem_in = ty_rem_c;
      done_in   = done_c;

      if (emit) begin
         if (dx_inc >= DX_W'(OUT_SIZE)) begin
            dx_in     = '0;
            tx_in     = COL_W'(TX_INIT);
            tx_rem_in = REM_W'(TX_REM_INIT);
            if (dy_inc >= DX_W'(OUT_SIZE)) begin
               dy_in     = '0;
               ty_in     = ROW_W'(TY_INIT);
               ty_rem_in = REM_W'(TY_REM_INIT);
               last      = 1'b1;
               done_in   = 1'b1;
            end else begin
               dy_in     = dy_inc;
               ty_in     = ty_sum[ROW_W-1:0];
               ty_rem_in = ty_carry ? ty_rem_sum - REM_W'(OUT_SIZE) : ty_rem_sum;
            end
         end else begin
            dx_in     = dx_inc;
            tx_in     = tx_sum[COL_W-1:0];
            tx_rem_in = tx_carry ? tx_rem_sum - REM_W'(OUT_SIZE) : tx_rem_sum;
         end
      end

      // A dropped beat outside a frame leaves the source position alone.
      if (!done_c) begin
         if (col_inc >= COL_W'(SOURCE_WIDTH)) begin
            col_in = '0;
            if (row_c < ROW_W'(SOURCE_HEIGHT)) begin
               row_in = row_c + ROW_W'(1);
            end
         end else begin
            col_in = col_inc;
         end
      end
   end

   always_comb begin
      red_p   = scale_chan(WIDEN5[req_tdata[15:11]], inv_scale_ff);
      green_p = scale_chan(WIDEN6[req_tdata[10:5]], inv_scale_ff);
      blue_p  = scale_chan(WIDEN5[req_tdata[4:0]], inv_scale_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_scale_ff <= INV_SCALE_RESET;
         zp_offset_ff <= ZP_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_INVERSE_SCALE: inv_scale_ff <= csr_wdata;
            CSR_ZERO_POINT:    zp_offset_ff <= csr_wdata[ZP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         dx_ff     <= '0;
         dy_ff     <= '0;
         tx_ff     <= COL_W'(TX_INIT);
         ty_ff     <= ROW_W'(TY_INIT);
         tx_rem_ff <= REM_W'(TX_REM_INIT);
         ty_rem_ff <= REM_W'(TY_REM_INIT);
         done_ff   <= 1'b1;
      end else if (accept) begin
         col_ff    <= col_in;
         row_ff    <= row_in;
         dx_ff     <= dx_in;
         dy_ff     <= dy_in;
         tx_ff     <= tx_in;
         ty_ff     <= ty_in;
         tx_rem_ff <= tx_rem_in;
         ty_rem_ff <= ty_rem_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= accept && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_red_ff   <= red_p;
         s1_green_ff <= green_p;
         s1_blue_ff  <= blue_p;
         s1_col_ff   <= POS_W'(dx_c);
         s1_row_ff   <= POS_W'(dy_c);
         s1_last_ff  <= last;
      end
   end

   rsq_round u_round_red (
      .chan      (s1_red_ff),
      .zp_offset (zp_offset_ff),
      .q         (red_q)
   );

   rsq_round u_round_green (
      .chan      (s1_green_ff),
      .zp_offset (zp_offset_ff),
      .q         (green_q)
   );

   rsq_round u_round_blue (
      .chan      (s1_blue_ff),
      .zp_offset (zp_offset_ff),
      .q         (blue_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_ready) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_ready && s1_valid_ff) begin
         rsp_red_ff   <= red_q;
         rsp_green_ff <= green_q;
         rsp_blue_ff  <= blue_q;
         rsp_col_ff   <= s1_col_ff;
         rsp_row_ff   <= s1_row_ff;
         rsp_last_ff  <= s1_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_row_ff, rsp_col_ff, rsp_blue_ff, rsp_green_ff, rsp_red_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

[tb/sv/rgb565_resize_int8_quantizer_core_tb.sv]
// Self-checking testbench for rgb565_resize_int8_quantizer_core at its default geometry.
// A scoreboard class predicts every sampled, quantized pixel; plain tasks drive req and CSR.
// Depends on rsq_pkg and the core RTL only.
`timescale 1ns / 1ps

module rgb565_resize_int8_quantizer_core_tb;
   import rsq_pkg::*;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [6:0] column;
      logic [6:0] row;
      logic       eof;
   } qpixel_type;

   class quant_scoreboard;
      logic [INV_SCALE_W-1:0] inv_scale;
      logic signed [7:0]      zero_pt;
      int unsigned            src_col;
      int unsigned            src_row;
      int unsigned            dst_col;
      int unsigned            dst_row;
      bit                     waiting_sof;
      qpixel_type             expected_q[$];
      int                     mismatches;
      int                     beats_checked;
      int                     frames_closed;
      int                     pixels_taken;

      function new();
         inv_scale     = INV_SCALE_RESET;
         zero_pt       = ZP_RESET;
         src_col       = 0;
         src_row       = 0;
         dst_col       = 0;
         dst_row       = 0;
         waiting_sof   = 1'b1;
         mismatches    = 0;
         beats_checked = 0;
         frames_closed = 0;
         pixels_taken  = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] reg_index,
                              logic [INV_SCALE_W-1:0] value);
         case (reg_index)
            CSR_INVERSE_SCALE: inv_scale = value;
            CSR_ZERO_POINT:    zero_pt = value[7:0];
            default: ;
         endcase
      endfunction

      // Maps an 8-bit level to [-1,1], scales it, rounds half away from zero and saturates.
      function logic [7:0] quantize(int unsigned level);
         longint den;
         longint prod;
         longint mag;
         longint rounded;
         longint q;
         den     = 255 * 65536;
         prod    = (longint'(level) * 2 - 255) * longint'(inv_scale);
         mag     = (prod < 0) ? -prod : prod;
         rounded = (mag + den / 2) / den;
         q       = ((prod < 0) ? -rounded : rounded) + longint'(zero_pt);
         if (q > 127) q = 127;
         else if (q < -128) q = -128;
         return q[7:0];
      endfunction

      function void note_pixel(logic [15:0] px, logic sof);
         int unsigned tgt_row;
         int unsigned tgt_col;
         qpixel_type  exp_px;
         pixels_taken++;
         if (sof) begin
            src_col     = 0;
            src_row     = 0;
            dst_col     = 0;
            dst_row     = 0;
            waiting_sof = 1'b0;
         end
         if (waiting_sof) return;
         tgt_row = (dst_row * SOURCE_HEIGHT_DEF + SOURCE_HEIGHT_DEF / 2) / OUT_SIZE_DEF;
         tgt_col = (dst_col * SOURCE_WIDTH_DEF + SOURCE_WIDTH_DEF / 2) / OUT_SIZE_DEF;
         if (src_row >= tgt_row && src_col >= tgt_col) begin
            exp_px.red    = quantize(int'(px[15:11]) * 255 / 31);
            exp_px.green  = quantize(int'(px[10:5]) * 255 / 63);
            exp_px.blue   = quantize(int'(px[4:0]) * 255 / 31);
            exp_px.column = dst_col[6:0];
            exp_px.row    = dst_row[6:0];
            exp_px.eof    = 1'b0;
            dst_col++;
            if (dst_col >= OUT_SIZE_DEF) begin
               dst_col = 0;
               dst_row++;
               if (dst_row >= OUT_SIZE_DEF) begin
                  dst_row     = 0;
                  exp_px.eof  = 1'b1;
                  waiting_sof = 1'b1;
               end
            end
            expected_q.push_back(exp_px);
         end
         src_col++;
         if (src_col >= SOURCE_WIDTH_DEF) begin
            src_col = 0;
            if (src_row < SOURCE_HEIGHT_DEF) src_row++;
         end
      endfunction

      function void check_beat(logic [39:0] data, logic last);
         qpixel_type got;
         qpixel_type want;
         got = {data[7:0], data[15:8], data[23:16], data[30:24], data[37:31], last};
         beats_checked++;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("[%0t] rsp beat with nothing expected: tdata=%h tlast=%b",
                        $time, data, last);
            return;
         end
         want = expected_q.pop_front();
         if (want.eof) frames_closed++;
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("[%0t] rsp mismatch, expected r=%0d g=%0d b=%0d col=%0d row=%0d last=%b",
                        $time, $signed(want.red), $signed(want.green), $signed(want.blue),
                        want.column, want.row, want.eof);
               $display("            actual   r=%0d g=%0d b=%0d col=%0d row=%0d last=%b",
                        $signed(got.red), $signed(got.green), $signed(got.blue),
                        got.column, got.row, got.eof);
            end
         end
      endfunction
   endclass

   localparam int CYCLE_LIMIT = 500_000;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [INV_SCALE_W-1:0] csr_wdata;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [15:0]            req_tdata;   // pixel[15:0]
   logic [0:0]             req_tuser;   // start_of_frame[0]
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // red_q[7:0], green_q[15:8], blue_q[23:16], out_column[30:24], out_row[37:31], zero pad
   logic [39:0]            rsp_tdata;
   logic                   rsp_tlast;   // end_of_frame

   quant_scoreboard sb;
   int              cycle_count  = 0;
   int              tx_idle_pct  = 20;
   int              rx_idle_pct  = 25;
   int              rsp_hold_req = 0;

   rgb565_resize_int8_quantizer_core dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_pixel(req_tdata, req_tuser[0]);
         if (rsp_tvalid && rsp_tready) sb.check_beat(rsp_tdata, rsp_tlast);
      end
   end

   // Mostly short idle stretches, now and then a long one.
   function automatic int idle_length();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [15:0] corner_pixel(int k);
      case (k)
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'hF800;
         3: return 16'h07E0;
         4: return 16'h001F;
         5: return 16'h8410;  // lowest codes that widen above mid-scale
         6: return 16'h7BEF;  // highest codes that widen below mid-scale
         7: return 16'h0821;
         8: return 16'hF7DE;
         default: return 16'h5555;
      endcase
   endfunction

   function automatic logic [15:0] random_pixel();
      if ($urandom_range(0, 4) == 0) return corner_pixel($urandom_range(0, 9));
      return 16'($urandom);
   endfunction

   // A long hold request is counted down here, independent of the sender.
   initial begin : rsp_sink
      int hold_left;
      int gap_left;
      hold_left  = 0;
      gap_left   = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_req > 0) begin
            hold_left    = rsp_hold_req;
            rsp_hold_req = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(0, 99) >= rx_idle_pct) begin
            rsp_tready <= 1'b1;
         end else begin
            gap_left = idle_length() - 1;
            rsp_tready <= 1'b0;
         end
      end
   end

   task automatic send_pixel(logic [15:0] px, logic sof);
      int gap;
      gap = ($urandom_range(0, 99) < tx_idle_pct) ? idle_length() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      req_tuser  <= sof;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] reg_index, logic [INV_SCALE_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= reg_index;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_reg(reg_index, value);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic reconfigure(logic [INV_SCALE_W-1:0] scale, logic [7:0] zp);
      drain_results();
      // Dropped pixels may still be in the two-stage pipeline.
      repeat (4) @(posedge clock);
      write_csr(CSR_INVERSE_SCALE, scale);
      write_csr(CSR_ZERO_POINT, {16'd0, zp});
   endtask

   // Starts a frame, lets source row 0 pass unsampled and then walks source row 1, the
   // first sampled row, with the corner pixels on its sampled columns. The scale and
   // zero point change between segments of that row, and the receiver stalls for a long
   // stretch in the middle of it. The next frame start cuts the frame short.
   task automatic corner_frame();
      int          k;
      int          col;
      logic [15:0] px;
      k = 0;
      for (int i = 0; i < 2 * SOURCE_WIDTH_DEF; i++) begin
         col = i - SOURCE_WIDTH_DEF;
         px  = random_pixel();
         if (col >= 0 &&
             col == (k * SOURCE_WIDTH_DEF + SOURCE_WIDTH_DEF / 2) / OUT_SIZE_DEF) begin
            px = corner_pixel(k % 10);
            k++;
         end
         case (col)
            48:  reconfigure(24'hFFFFFF, 8'd127);
            96:  reconfigure(24'h000000, 8'h80);
            120: rsp_hold_req = 80;
            144: reconfigure(24'h000001, 8'd0);
            192: reconfigure(24'h010000, 8'h80);
            default: ;
         endcase
         send_pixel(px, i == 0);
      end
   endtask

   // Partial frames of random length with random content and occasional stray frame starts.
   task automatic random_run(int count);
      int seq_len;
      int pos;
      seq_len = 0;
      pos     = 0;
      for (int i = 0; i < count; i++) begin
         if (pos >= seq_len) begin
            pos     = 0;
            seq_len = $urandom_range(260, 720);
         end
         if ($urandom_range(0, 299) == 0) drain_results();
         send_pixel(random_pixel(), pos == 0 || $urandom_range(0, 199) == 0);
         pos++;
      end
   endtask

   initial begin
      sb         = new();
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Nothing may come out before the first frame start.
      send_pixel(16'hFFFF, 1'b0);
      send_pixel(corner_pixel(5), 1'b0);
      send_pixel(16'h0000, 1'b0);
      corner_frame();
      reconfigure(24'($urandom), 8'($urandom));
      random_run(320);

      drain_results();
      repeat (10) @(posedge clock);
      $display("Accepted %0d pixels and checked %0d quantized beats, %0d of them closing a frame.",
               sb.pixels_taken, sb.beats_checked, sb.frames_closed);
      $display("Corner codes under scale and zero point extremes, aborted frames and a long %s%0d",
               "output stall were exercised; mismatches: ", sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

[sim.f]
sv/rsq_pkg.sv
sv/rsq_round.sv
sv/rgb565_resize_int8_quantizer_core.sv
tb/sv/rgb565_resize_int8_quantizer_core_tb.sv
